>>> hw/rtl/smfb_pkg.sv
// Package for the sector median filter bank: shared constants, register
// indexes, the sequencer state type and the rank unit control struct.
// No dependencies; smfb_rank and the top level use it.
package smfb_pkg;

	// Defaults for the top-level parameters.
	localparam int NUM_SECTORS_DEF = 32;
	localparam int MAX_WINDOW_DEF  = 16;

	// Fixed field widths.
	localparam int SECTOR_W = 5;
	localparam int SAMPLE_W = 24;
	localparam int WLEN_W   = 5;

	// Configuration port geometry.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register indexes, decoded from paddr[2].
	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic REG_EMPTY_CODE    = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [WLEN_W-1:0]          WLEN_RST       = 5'd1;
	localparam logic signed [SAMPLE_W-1:0] EMPTY_CODE_RST = -24'sd1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_SEL,
		ST_OUT
	} state_t;

	// Control of the rank unit by the sequencer.
	typedef struct packed {
		logic clr;   // drop every lane (start of a new item)
		logic load;  // shift one read beat into lane zero
		logic rot;   // rotate the lanes to bring up the next candidate
	} rank_ctrl_t;

endpackage

>>> hw/rtl/smfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; instanced for the window store.
module smfb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/smfb_rank.sv
// Rank unit: a line of window lanes and one shared row of comparators that
// ranks the candidate in lane zero against all valid lanes each cycle.
// Depends on smfb_pkg.
module smfb_rank #(
	parameter int MAX_WINDOW = smfb_pkg::MAX_WINDOW_DEF,
	parameter int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  smfb_pkg::rank_ctrl_t                ctrl,
	input  logic signed [smfb_pkg::SAMPLE_W-1:0] din,
	input  logic [CNT_W-1:0]                    k,
	output logic signed [smfb_pkg::SAMPLE_W-1:0] cand,
	output logic                                hit
);

	logic signed [smfb_pkg::SAMPLE_W-1:0] lane_q [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]                vld_q;
	logic [CNT_W-1:0]                     less;
	logic [CNT_W-1:0]                     leq;

	// Lane valid bits: cleared per item, filled from lane zero, rotated with data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctrl.clr) begin
			vld_q <= '0;
		end else if (ctrl.load) begin
			vld_q[0] <= 1'b1;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end else if (ctrl.rot) begin
			vld_q[MAX_WINDOW-1] <= vld_q[0];
			for (int i = 0; i < MAX_WINDOW - 1; i++) begin
				vld_q[i] <= vld_q[i+1];
			end
		end
	end

	// Lane data follows the same shifts.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			lane_q[0] <= din;
			for (int i = 1; i < MAX_WINDOW; i++) begin
				lane_q[i] <= lane_q[i-1];
			end
		end else if (ctrl.rot) begin
			lane_q[MAX_WINDOW-1] <= lane_q[0];
			for (int i = 0; i < MAX_WINDOW - 1; i++) begin
				lane_q[i] <= lane_q[i+1];
			end
		end
	end

	assign cand = lane_q[0];

	// Count the valid lanes strictly below and at most equal to the candidate.
	always_comb begin
		less = '0;
		leq  = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (vld_q[i] && (lane_q[i] < cand)) begin
				less = less + CNT_W'(1);
			end
			if (vld_q[i] && (lane_q[i] <= cand)) begin
				leq = leq + CNT_W'(1);
			end
		end
	end

	// The candidate is the k-th smallest when k falls in its run of equals.
	assign hit = vld_q[0] && (less < k) && (k <= leq);

endmodule

>>> hw/rtl/sector_median_filter_bank_unit.sv
// Sector median filter bank: top level with configuration registers, per-sector
// ring pointers and fill counts, the sequencer and the output register.
// Depends on smfb_pkg, smfb_ram and smfb_rank.
//
// Usage:
//   Input beats carry the sector in s_tuser and the sample in s_tdata. Each
//   beat yields exactly one output beat on m_tdata: the lower median of that
//   sector's window after the sample is pushed. A sector at or above
//   NUM_SECTORS changes nothing and returns the current empty code.
//   One beat is handled at a time. For a window holding n samples the beat
//   goes through n reads of the window store, the load of the last read
//   data into the rank unit, the start of ranking, up to n rank steps of
//   the shared comparator row, and the load of the output register. The
//   next beat can be taken in the cycle after that load. An unknown sector
//   goes from acceptance straight to the output state. A stalled m_tready
//   holds the result; the next one then waits in the sequencer, with
//   s_tready low, until the output register frees.
//   After reset a clearing pass fills all NUM_SECTORS*MAX_WINDOW entries of
//   the window store with the reset empty code; s_tready stays low meanwhile.
//   Registers: window_length at byte 0, empty_code at byte 4; pready is high.
module sector_median_filter_bank_unit #(
	parameter int NUM_SECTORS = smfb_pkg::NUM_SECTORS_DEF,
	parameter int MAX_WINDOW  = smfb_pkg::MAX_WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [smfb_pkg::SAMPLE_W-1:0]       s_tdata,  // [23:0] sample_value
	input  logic [smfb_pkg::SECTOR_W-1:0]       s_tuser,  // [4:0] sector_index
	// Output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [smfb_pkg::SAMPLE_W-1:0]       m_tdata,  // [23:0] median_value
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [smfb_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [smfb_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [smfb_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int DEPTH  = NUM_SECTORS * MAX_WINDOW;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SEC_W  = $clog2(NUM_SECTORS);
	localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SW     = smfb_pkg::SAMPLE_W;

	smfb_pkg::state_t     state_q;
	smfb_pkg::state_t     state_d;
	smfb_pkg::rank_ctrl_t rank_ctrl;

	// Configuration and per-sector state
	logic [CNT_W-1:0]     wl_q;
	logic signed [SW-1:0] empty_q;
	logic [PTR_W-1:0]     wp_q [NUM_SECTORS];
	logic [CNT_W-1:0]     fill_q [NUM_SECTORS];

	// Sequencer registers
	logic [ADDR_W-1:0]    clr_addr_q;
	logic [ADDR_W-1:0]    row_base_q;
	logic [PTR_W-1:0]     rp_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     k_q;
	logic [CNT_W-1:0]     iss_q;
	logic                 rd_pend_q;
	logic signed [SW-1:0] res_q;
	logic                 out_vld_q;
	logic [SW-1:0]        out_data_q;

	// Accept-cycle decode
	logic                 s_acc;
	logic                 sec_ok;
	logic [SEC_W-1:0]     sec_idx;
	logic [PTR_W-1:0]     wp_cur;
	logic [PTR_W-1:0]     wp_next;
	logic [CNT_W-1:0]     fill_cur;
	logic [CNT_W:0]       cnt_inc;
	logic [CNT_W-1:0]     cnt_new;
	logic [CNT_W:0]       k_sum;
	logic [CNT_W-1:0]     k_new;
	logic [ADDR_W-1:0]    row_base;

	// Control decode
	logic                 issue;
	logic                 out_load;
	logic                 cfg_wr;
	logic [smfb_pkg::WLEN_W-1:0] wl_wr;
	logic [CNT_W-1:0]     wl_sat;

	// Memory and rank unit signals
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [SW-1:0]        ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [SW-1:0]        ram_rdata;
	logic signed [SW-1:0] cand;
	logic                 hit;

	// Accept and per-sector lookups for the new sample.
	assign s_acc    = s_tvalid && s_tready;
	assign sec_ok   = (32'(s_tuser) < NUM_SECTORS);
	assign sec_idx  = SEC_W'(s_tuser);
	assign wp_cur   = wp_q[sec_idx];
	assign fill_cur = fill_q[sec_idx];
	assign wp_next  = (wp_cur == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_cur + PTR_W'(1);
	assign cnt_inc  = {1'b0, fill_cur} + (CNT_W + 1)'(1);
	assign cnt_new  = (cnt_inc > {1'b0, wl_q}) ? wl_q : cnt_inc[CNT_W-1:0];
	assign k_sum    = ({1'b0, cnt_new} + (CNT_W + 1)'(1)) >> 1;
	assign k_new    = k_sum[CNT_W-1:0];
	assign row_base = ADDR_W'(ADDR_W'(sec_idx) * ADDR_W'(MAX_WINDOW));

	// Configuration write decode; window length saturates at the ring size.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign wl_wr  = pwdata[smfb_pkg::WLEN_W-1:0];
	assign wl_sat = (32'(wl_wr) > MAX_WINDOW) ? CNT_W'(MAX_WINDOW) : CNT_W'(wl_wr);

	// Register read-back.
	always_comb begin
		case (paddr[2])
			smfb_pkg::REG_WINDOW_LENGTH: prdata = smfb_pkg::APB_DATA_W'(wl_q);
			smfb_pkg::REG_EMPTY_CODE:    prdata = smfb_pkg::APB_DATA_W'(unsigned'(empty_q));
			default:                     prdata = '0;
		endcase
	end

	// Configuration registers, ring pointers and fill counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= CNT_W'(smfb_pkg::WLEN_RST);
			empty_q <= smfb_pkg::EMPTY_CODE_RST;
			for (int s = 0; s < NUM_SECTORS; s++) begin
				wp_q[s]   <= '0;
				fill_q[s] <= CNT_W'(1);
			end
		end else begin
			if (cfg_wr && (paddr[2] == smfb_pkg::REG_WINDOW_LENGTH) && (wl_wr != '0)) begin
				wl_q <= wl_sat;
				// A shorter window keeps only the newest entries of each ring.
				for (int s = 0; s < NUM_SECTORS; s++) begin
					if (fill_q[s] > wl_sat) begin
						fill_q[s] <= wl_sat;
					end
				end
			end
			if (cfg_wr && (paddr[2] == smfb_pkg::REG_EMPTY_CODE)) begin
				empty_q <= signed'(pwdata[SW-1:0]);
			end
			if (s_acc && sec_ok) begin
				wp_q[sec_idx]   <= wp_next;
				fill_q[sec_idx] <= cnt_new;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			smfb_pkg::ST_CLEAR: begin
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = smfb_pkg::ST_IDLE;
				end
			end
			smfb_pkg::ST_IDLE: begin
				if (s_acc) begin
					state_d = sec_ok ? smfb_pkg::ST_LOAD : smfb_pkg::ST_OUT;
				end
			end
			smfb_pkg::ST_LOAD: begin
				if ((iss_q == cnt_q) && !rd_pend_q) begin
					state_d = smfb_pkg::ST_SEL;
				end
			end
			smfb_pkg::ST_SEL: begin
				if (hit) begin
					state_d = smfb_pkg::ST_OUT;
				end
			end
			smfb_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = smfb_pkg::ST_IDLE;
				end
			end
			default: state_d = smfb_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready       = (state_q == smfb_pkg::ST_IDLE);
		issue          = (state_q == smfb_pkg::ST_LOAD) && (iss_q != cnt_q);
		out_load       = (state_q == smfb_pkg::ST_OUT) && (!out_vld_q || m_tready);
		rank_ctrl.clr  = s_acc;
		rank_ctrl.load = rd_pend_q;
		rank_ctrl.rot  = (state_q == smfb_pkg::ST_SEL) && !hit;
	end

	// State register, clearing sweep, read issue and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= smfb_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			iss_q      <= '0;
			rd_pend_q  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= issue;
			if (state_q == smfb_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (s_acc) begin
				iss_q <= '0;
			end else if (issue) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Item payload: ring row, read pointer, count, rank and result.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			row_base_q <= row_base;
			rp_q       <= wp_cur;
			cnt_q      <= cnt_new;
			k_q        <= k_new;
			if (!sec_ok) begin
				res_q <= empty_q;
			end
		end else if (issue) begin
			// Walk backwards from the newest slot.
			rp_q <= (rp_q == '0) ? PTR_W'(MAX_WINDOW - 1) : rp_q - PTR_W'(1);
		end
		if ((state_q == smfb_pkg::ST_SEL) && hit) begin
			res_q <= cand;
		end
		if (out_load) begin
			out_data_q <= res_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// Window store ports: clearing sweep or the new sample, and ring reads.
	always_comb begin
		if (state_q == smfb_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = smfb_pkg::EMPTY_CODE_RST;
		end else begin
			ram_we    = s_acc && sec_ok;
			ram_waddr = row_base + ADDR_W'(wp_cur);
			ram_wdata = s_tdata;
		end
	end

	assign ram_raddr = row_base_q + ADDR_W'(rp_q);

	smfb_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	smfb_rank #(
		.MAX_WINDOW (MAX_WINDOW),
		.CNT_W      (CNT_W)
	) u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rank_ctrl),
		.din    (signed'(ram_rdata)),
		.k      (k_q),
		.cand   (cand),
		.hit    (hit)
	);

	// The window length always stays within the ring.
	a_wl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wl_q != '0) && (32'(wl_q) <= MAX_WINDOW))
		else $error("window length out of range");

	// Ranking only runs with a sensible rank within the loaded count.
	a_rank_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == smfb_pkg::ST_SEL) |-> ((k_q != '0) && (k_q <= cnt_q)))
		else $error("rank outside the window count");

	// A sector's fill count never exceeds the window length.
	a_fill_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && sec_ok) |-> (fill_cur <= wl_q))
		else $error("fill count above window length");

	// A new result only appears from the output state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == smfb_pkg::ST_OUT))
		else $error("result raised outside the output state");

endmodule

>>> tb/smfb_median_check.sv
// Checker for the sector median filter bank: watches the APB port and both streams,
// keeps its own copy of every sector window and compares each output beat with it.
// Depends on smfb_pkg for field widths and register indexes.
module smfb_median_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [smfb_pkg::SAMPLE_W-1:0]      s_tdata,  // [23:0] sample_value
	input  logic [smfb_pkg::SECTOR_W-1:0]      s_tuser,  // [4:0] sector_index
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [smfb_pkg::SAMPLE_W-1:0]      m_tdata,  // [23:0] median_value
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [smfb_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [smfb_pkg::APB_DATA_W-1:0]    pwdata,
	input  logic [smfb_pkg::APB_DATA_W-1:0]    prdata,
	input  logic                               pready,
	output int                                 fail_count,
	output int                                 results_seen,
	output int                                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import smfb_pkg::*;

	localparam int SECTORS   = NUM_SECTORS_DEF;
	localparam int DEPTH     = MAX_WINDOW_DEF;
	localparam int MAX_LINES = 40;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct {
		logic [SECTOR_W-1:0] sector;
		sample_t             median;
	} median_entry_t;

	// Shadow of the block: one ring per sector, its write slot and its fill level.
	sample_t           ring [SECTORS][DEPTH];
	int unsigned       head [SECTORS];
	int unsigned       held [SECTORS];
	logic [WLEN_W-1:0] win_len;
	sample_t           empty_val;

	median_entry_t     median_q [$];
	median_entry_t     due;

	// One line per mismatch, capped so a broken block cannot flood the log.
	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_LINES)
			$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_model();
		win_len   = WLEN_RST;
		empty_val = EMPTY_CODE_RST;
		for (int s = 0; s < SECTORS; s++) begin
			for (int i = 0; i < DEPTH; i++)
				ring[s][i] = EMPTY_CODE_RST;
			head[s] = 0;
			held[s] = 1;
		end
	endtask

	// A zero length is dropped, an oversized one clamps, and shrinking trims every window.
	task automatic apply_write(input logic idx, input logic [APB_DATA_W-1:0] data);
		logic [WLEN_W-1:0] len;
		if (idx == REG_WINDOW_LENGTH) begin
			len = data[WLEN_W-1:0];
			if (len != 0) begin
				if (len > DEPTH)
					len = WLEN_W'(DEPTH);
				win_len = len;
				for (int s = 0; s < SECTORS; s++)
					if (held[s] > len)
						held[s] = 32'(len);
			end
		end else begin
			empty_val = data[SAMPLE_W-1:0];
		end
	endtask

	task automatic check_readback(input logic idx, input logic [APB_DATA_W-1:0] data);
		if (idx == REG_WINDOW_LENGTH) begin
			if (data[WLEN_W-1:0] !== win_len)
				report_mismatch($sformatf("window_length reads %0d, holds %0d",
					data[WLEN_W-1:0], win_len));
		end else if (data[SAMPLE_W-1:0] !== empty_val) begin
			report_mismatch($sformatf("empty_code reads %0d, holds %0d",
				$signed(data[SAMPLE_W-1:0]), empty_val));
		end
	endtask

	// Push one sample and return the lower median of the newest entries.
	// The window is gathered newest first and insertion-sorted on the way.
	function automatic sample_t push_and_rank(input int unsigned sec, input sample_t v);
		sample_t     sorted [DEPTH];
		sample_t     cur;
		int unsigned n;
		int unsigned pos;
		int unsigned j;
		if (sec >= SECTORS)
			return empty_val;
		ring[sec][head[sec]] = v;
		head[sec] = (head[sec] + 1) % DEPTH;
		n = held[sec] + 1;
		if (n > win_len)
			n = 32'(win_len);
		held[sec] = n;
		pos = head[sec];
		for (int i = 0; i < n; i++) begin
			pos = (pos + DEPTH - 1) % DEPTH;
			cur = ring[sec][pos];
			j = i;
			while (j > 0 && sorted[j-1] > cur) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = cur;
		end
		return sorted[(n + 1) / 2 - 1];
	endfunction

	// Everything is sampled at the rising edge, before any update of that edge lands.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			median_q.delete();
			fail_count = 0;
			results_seen <= 0;
			outstanding  <= 0;
		end else begin
			// Register beats.
			if (psel && penable && pready) begin
				if (pwrite)
					apply_write(paddr[2], pwdata);
				else
					check_readback(paddr[2], prdata);
			end

			// Input beat: predict its median and queue it at the back.
			if (s_tvalid && s_tready) begin
				due.sector = s_tuser;
				due.median = push_and_rank(32'(s_tuser), $signed(s_tdata));
				median_q = {median_q, due};
			end

			// Output beat: compare with the oldest prediction.
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (median_q.size() == 0) begin
					report_mismatch($sformatf("median %0d with no input beat waiting",
						$signed(m_tdata)));
				end else begin
					due = median_q.pop_front();
					if (m_tdata !== due.median)
						report_mismatch($sformatf("sector %0d median got %0d expected %0d",
							due.sector, $signed(m_tdata), due.median));
				end
			end

			outstanding <= median_q.size();
		end
	end

endmodule

>>> tb/sector_median_filter_bank_unit_tb.sv
// Testbench top for the sector median filter bank: clock, reset, stream and APB
// stimulus with random idling, and the verdict.
// Depends on smfb_pkg, the block itself and the smfb_median_check checker.
module sector_median_filter_bank_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import smfb_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int SECTORS      = NUM_SECTORS_DEF;
	localparam int DEPTH        = MAX_WINDOW_DEF;
	localparam int SLOWEST      = 2 * DEPTH + 3;
	localparam int HOLD_CYCLES  = 300;
	localparam int SEGMENTS     = 8;
	localparam int SEG_BEATS    = 125;
	// Far above the slowest expected run.
	localparam int LIMIT_CYCLES = 1_000_000;

	localparam logic [APB_ADDR_W-1:0] ADDR_WLEN  = {REG_WINDOW_LENGTH, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_EMPTY = {REG_EMPTY_CODE, 2'b00};

	// Window lengths per segment: zero is ignored, 31 clamps to the maximum.
	localparam logic [APB_DATA_W-1:0] WLEN_PLAN [SEGMENTS] = '{16, 1, 31, 2, 0, 7, 16, 12};
	localparam logic [APB_DATA_W-1:0] CODE_PLAN [3] = '{32'h007FFFFF, 32'hFF800000, 32'h0};

	// Samples for one sector, enough to wrap its ring with duplicates and extremes.
	localparam logic [SAMPLE_W-1:0] RAMP [18] = '{
		24'h000009, 24'h000009, 24'hFFFFFD, 24'h7FFFFF, 24'h800000, 24'h000009,
		24'h000001, 24'h000002, 24'h000003, 24'h000000, 24'h000000, 24'hFFFFFF,
		24'h0003E8, 24'h0003E7, 24'h000009, 24'h7FFFFF, 24'h000005, 24'h000005};

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata  = '0;  // [23:0] sample_value
	logic [SECTOR_W-1:0]   s_tuser  = '0;  // [4:0] sector_index
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [SAMPLE_W-1:0]   m_tdata;        // [23:0] median_value
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int fail_count;
	int results_seen;
	int outstanding;
	int sent_count     = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	bit hold_sink      = 1'b0;

	sector_median_filter_bank_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	smfb_median_check u_median_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.fail_count   (fail_count),
		.results_seen (results_seen),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Output side: random stalls, or one long hold-off counted here when requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_sink = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Offer one beat after a random idle stretch and wait until it is taken.
	task automatic send_sample(input logic [SECTOR_W-1:0] sector,
			input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= sector;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	// Stop offering and wait until every median has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (results_seen < sent_count)
			@(posedge clk);
	endtask

	// One APB transfer; psel stays up so transfers can follow back to back.
	task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Write and read back both registers while the block is idle.
	task automatic configure(input logic [APB_DATA_W-1:0] wlen,
			input logic [APB_DATA_W-1:0] code);
		drain_results();
		apb_access(1'b1, ADDR_WLEN, wlen);
		apb_access(1'b0, ADDR_WLEN, '0);
		apb_access(1'b1, ADDR_EMPTY, code);
		apb_access(1'b0, ADDR_EMPTY, '0);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Most beats hit a few neighboring sectors so that windows fill and wrap.
	function automatic logic [SECTOR_W-1:0] pick_sector(input int unsigned hot);
		if ($urandom_range(3) != 0)
			return SECTOR_W'(hot + $urandom_range(3));
		return SECTOR_W'($urandom_range(SECTORS - 1));
	endfunction

	// Full-range, small repeating, extreme, small negative and mid-range values.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0, 1, 2, 3: return SAMPLE_W'($urandom);
			4, 5, 6:    return SAMPLE_W'($urandom_range(9));
			7:          return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			8:          return 24'hFFFFFF - SAMPLE_W'($urandom_range(3));
			default:    return SAMPLE_W'($urandom_range(5000, 200));
		endcase
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a window of one returns the sample itself.
		send_sample(0, 24'h7FFFFF);
		send_sample(31, 24'h800000);
		send_sample(1, 24'h000000);

		// Growing the window: the reset empty code still sits behind the first sample.
		configure(3, 32'h00123456);
		send_sample(5, 24'd100);
		send_sample(5, 24'd50);
		send_sample(5, 24'd200);

		// A zero length is ignored, so the window stays at three.
		configure(0, 32'hFF800000);
		send_sample(5, 24'd7);

		// An oversized length clamps; the ramp wraps one sector's ring.
		configure(17, 32'h007FFFFF);
		foreach (RAMP[i])
			send_sample(6, RAMP[i]);

		// Shrinking keeps only the newest entries.
		configure(4, 32'hFFFFFFFF);
		send_sample(6, 24'd4);

		// Random segments, two per idling pattern.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 60; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 60; end
				default: begin src_idle_pct = 24; sink_stall_pct = 24; end
			endcase
			configure(WLEN_PLAN[seg], (seg < 3) ? CODE_PLAN[seg] : $urandom);
			begin : segment
				int unsigned hot;
				hot = $urandom_range(SECTORS - 4);
				for (int i = 0; i < SEG_BEATS; i++) begin
					// The sender keeps going while the output holds off.
					if ((seg == 0 && i == 40) || (seg == 5 && i == 60))
						hold_sink = 1'b1;
					send_sample(pick_sector(hot), pick_sample());
				end
			end
		end

		drain_results();
		repeat (SLOWEST + 8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("[sector_median_filter_bank_unit] OK");
		else
			$display("[sector_median_filter_bank_unit] ERROR");
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("[sector_median_filter_bank_unit] ERROR");
		$finish;
	end

endmodule
